[src/tlbpt_pkg.sv]
package tlbpt_pkg;

  localparam int unsigned TlbEntries = 16;
  localparam int unsigned PageCount  = 256;
  localparam int unsigned FrameCount = 128;
  localparam int unsigned PageBytes  = 256;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned PaddrW  = 15;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned EvictW  = 8;

  localparam logic [CfgW-1:0] CfgReset = 8'd128;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StTableRead,
    StEvict,
    StInstall,
    StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tag_compare;
    logic table_read;
    logic evict;
    logic install;
    logic finish;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tlb_hit;
    logic page_valid;
    logic need_evict;
  } status_t;

endpackage

[src/tlbpt_ram.sv]
module tlbpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/tlbpt_ctrl.sv]
module tlbpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tlbpt_pkg::status_t status_i,
  output tlbpt_pkg::ctrl_t   ctrl_o
);

  import tlbpt_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:      if (start) state_d = StLookup;
      StLookup:    state_d = status_i.tlb_hit ? StDone : StTableRead;
      StTableRead: begin
        if (status_i.page_valid || !status_i.need_evict) begin
          state_d = StInstall;
        end else begin
          state_d = StEvict;
        end
      end
      StEvict:     state_d = StInstall;
      StInstall:   state_d = StDone;
      StDone:      state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    unique case (state_q)
      StIdle:      begin busy = 1'b0; ctrl_o.capture = start; end
      StLookup:    ctrl_o.tag_compare = 1'b1;
      StTableRead: ctrl_o.table_read = 1'b1;
      StEvict:     ctrl_o.evict = 1'b1;
      StInstall:   ctrl_o.install = 1'b1;
      StDone:      ctrl_o.finish = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

endmodule

[src/tlbpt_datapath.sv]
module tlbpt_datapath #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TlbEntries,
  parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PageCount,
  parameter int unsigned FRAME_COUNT = tlbpt_pkg::FrameCount,
  parameter int unsigned PAGE_BYTES  = tlbpt_pkg::PageBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlbpt_pkg::ctrl_t              ctrl_i,
  output tlbpt_pkg::status_t            status_o,
  input  logic [tlbpt_pkg::CfgW-1:0]    frames_in_use_i,
  input  logic [tlbpt_pkg::AddrW-1:0]   logical_address_i,
  output logic                          done_o,
  output logic [tlbpt_pkg::PaddrW-1:0]  physical_address_o,
  output logic                          tlb_hit_o,
  output logic                          page_fault_o,
  output logic                          evicted_valid_o,
  output logic [tlbpt_pkg::EvictW-1:0]  evicted_page_o,
  output logic [tlbpt_pkg::CountW-1:0]  hit_total_o,
  output logic [tlbpt_pkg::CountW-1:0]  fault_total_o
);

  import tlbpt_pkg::*;

  localparam int unsigned TlbW   = $clog2(TLB_ENTRIES);
  localparam int unsigned PageW  = $clog2(PAGE_COUNT);
  localparam int unsigned FrameW = $clog2(FRAME_COUNT);
  localparam int unsigned OffW   = $clog2(PAGE_BYTES);
  localparam int unsigned FcntW  = $clog2(FRAME_COUNT + 1);

  // Captured transaction fields.
  logic [PageW-1:0] page_q;
  logic [OffW-1:0]  off_q;

  // TLB held in flip-flops: tags, frames and LRU ranks.
  logic             tlb_v_q    [TLB_ENTRIES];
  logic [PageW-1:0] tlb_page_q [TLB_ENTRIES];
  logic [FrameW-1:0] tlb_frm_q [TLB_ENTRIES];
  logic [TlbW-1:0]  tlb_rank_q [TLB_ENTRIES];

  // Page table valid bits; frame numbers live in a RAM.
  logic [PAGE_COUNT-1:0] pv_q;

  logic [FcntW-1:0]  alloc_q;
  logic [FrameW-1:0] vptr_q;
  logic [CountW-1:0] hits_q, faults_q;

  logic [FrameW-1:0] frame_q;
  logic              hit_q, fault_q, ev_valid_q;
  logic [PageW-1:0]  ev_page_q;
  logic              done_q;

  // TLB match search.
  logic             match;
  logic [TlbW-1:0]  match_idx;
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    for (int j = TLB_ENTRIES - 1; j >= 0; j--) begin
      if (tlb_v_q[j] && tlb_page_q[j] == page_q) begin
        match     = 1'b1;
        match_idx = TlbW'(j);
      end
    end
  end

  // Install slot: lowest invalid entry, else the lowest rank.
  logic            any_free;
  logic [TlbW-1:0] free_idx, lru_idx;
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    lru_idx  = '0;
    for (int j = TLB_ENTRIES - 1; j >= 0; j--) begin
      if (!tlb_v_q[j]) begin
        any_free = 1'b1;
        free_idx = TlbW'(j);
      end
      if (tlb_rank_q[j] == '0) lru_idx = TlbW'(j);
    end
  end

  // Frame limit clamped to 1..FRAME_COUNT.
  logic [FcntW-1:0] limit;
  always_comb begin
    if (frames_in_use_i == '0) begin
      limit = FcntW'(1);
    end else if (32'(frames_in_use_i) > FRAME_COUNT) begin
      limit = FcntW'(FRAME_COUNT);
    end else begin
      limit = FcntW'(frames_in_use_i);
    end
  end

  logic page_valid, need_evict;
  assign page_valid = pv_q[page_q];
  assign need_evict = !(alloc_q < limit);
  logic [FrameW-1:0] victim;
  assign victim = (FcntW'(vptr_q) >= alloc_q) ? '0 : vptr_q;

  assign status_o.tlb_hit    = match;
  assign status_o.page_valid = page_valid;
  assign status_o.need_evict = need_evict;

  // Page table frame RAM and frame owner RAM.
  logic             pt_we;
  logic [PageW-1:0] pt_raddr;
  logic [FrameW-1:0] pt_rdata;
  logic              fo_we;
  logic [PageW-1:0]  fo_rdata;

  assign pt_we    = ctrl_i.table_read && !page_valid;
  assign pt_raddr = ctrl_i.capture ? logical_address_i[OffW +: PageW] : page_q;
  assign fo_we    = pt_we;

  logic [FrameW-1:0] new_frame;
  assign new_frame = need_evict ? victim : FrameW'(alloc_q);

  tlbpt_ram #(.Width(FrameW), .Depth(PAGE_COUNT)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (page_q),
    .wdata_i (new_frame),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  tlbpt_ram #(.Width(PageW), .Depth(FRAME_COUNT)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (fo_we),
    .waddr_i (new_frame),
    .wdata_i (page_q),
    .raddr_i (new_frame),
    .rdata_o (fo_rdata)
  );

  // LRU update target and its old rank.
  logic            touch;
  logic [TlbW-1:0] touch_idx;
  assign touch     = (ctrl_i.tag_compare && match) || ctrl_i.install;
  assign touch_idx = ctrl_i.install ? (any_free ? free_idx : lru_idx) : match_idx;

  // TLB and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q     <= '0;
      alloc_q  <= '0;
      vptr_q   <= '0;
      hits_q   <= '0;
      faults_q <= '0;
      done_q   <= 1'b0;
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        tlb_v_q[j]    <= 1'b0;
        tlb_rank_q[j] <= '0;
      end
    end else begin
      done_q <= ctrl_i.finish;
      if (touch) begin
        for (int j = 0; j < TLB_ENTRIES; j++) begin
          if (TlbW'(j) == touch_idx) begin
            tlb_rank_q[j] <= TlbW'(TLB_ENTRIES - 1);
          end else if (tlb_rank_q[j] > tlb_rank_q[touch_idx]) begin
            tlb_rank_q[j] <= tlb_rank_q[j] - 1'b1;
          end
        end
      end
      if (ctrl_i.install) begin
        tlb_v_q[touch_idx] <= 1'b1;
      end
      if (pt_we) begin
        pv_q[page_q] <= 1'b1;
        if (need_evict) begin
          vptr_q <= (FcntW'(victim) + 1'b1 >= alloc_q) ? '0 : victim + 1'b1;
        end else begin
          alloc_q <= alloc_q + 1'b1;
        end
      end
      // Invalidate the evicted page in the table and in the TLB.
      if (ctrl_i.evict) begin
        if (fo_rdata != page_q) pv_q[fo_rdata] <= 1'b0;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
          if (tlb_v_q[j] && tlb_page_q[j] == fo_rdata) tlb_v_q[j] <= 1'b0;
        end
      end
      if (ctrl_i.finish) begin
        if (hit_q && hits_q != '1) hits_q <= hits_q + 1'b1;
        if (fault_q && faults_q != '1) faults_q <= faults_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      page_q     <= logical_address_i[OffW +: PageW];
      off_q      <= logical_address_i[OffW-1:0];
      hit_q      <= 1'b0;
      fault_q    <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
    end
    if (ctrl_i.tag_compare && match) begin
      hit_q   <= 1'b1;
      frame_q <= tlb_frm_q[match_idx];
    end
    if (ctrl_i.table_read) begin
      if (page_valid) begin
        frame_q <= pt_rdata;
      end else begin
        fault_q <= 1'b1;
        frame_q <= new_frame;
        ev_valid_q <= need_evict;
      end
    end
    if (ctrl_i.evict) ev_page_q <= fo_rdata;
    if (ctrl_i.install) begin
      tlb_page_q[touch_idx] <= page_q;
      tlb_frm_q[touch_idx]  <= frame_q;
    end
  end

  assign done_o             = done_q;
  assign physical_address_o = PaddrW'({frame_q, off_q});
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign evicted_valid_o    = ev_valid_q;
  assign evicted_page_o     = EvictW'(ev_page_q);
  assign hit_total_o        = hits_q;
  assign fault_total_o      = faults_q;

endmodule

[src/tlb_page_table_translator.sv]
// Translates one logical address per transaction. Pulse start while busy is
// low; the result appears for exactly one cycle with done_o high and cannot be
// stalled. A TLB hit needs only the TLB compare; a page-table hit adds the
// registered page-table read and the TLB install, and a fault that evicts a
// resident page also the owner read for eviction. frames_in_use is written
// over the cfg channel, always accepted.
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TlbEntries,
  parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PageCount,
  parameter int unsigned FRAME_COUNT = tlbpt_pkg::FrameCount,
  parameter int unsigned PAGE_BYTES  = tlbpt_pkg::PageBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tlbpt_pkg::AddrW-1:0]   logical_address_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tlbpt_pkg::CfgW-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic [tlbpt_pkg::PaddrW-1:0]  physical_address_o,
  output logic                          tlb_hit_o,
  output logic                          page_fault_o,
  output logic                          evicted_valid_o,
  output logic [tlbpt_pkg::EvictW-1:0]  evicted_page_o,
  output logic [tlbpt_pkg::CountW-1:0]  hit_total_o,
  output logic [tlbpt_pkg::CountW-1:0]  fault_total_o
);

  import tlbpt_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic [CfgW-1:0] frames_in_use_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CfgReset;
    end else if (cfg_valid_i) begin
      frames_in_use_q <= cfg_data_i;
    end
  end

  tlbpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .status_o           (status),
    .frames_in_use_i    (frames_in_use_q),
    .logical_address_i  (logical_address_i),
    .done_o             (done_o),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .evicted_valid_o    (evicted_valid_o),
    .evicted_page_o     (evicted_page_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

  // A hit is never a fault, and an eviction only comes with a fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(tlb_hit_o && page_fault_o))
    else $error("hit and fault reported together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_valid_o |-> page_fault_o)
    else $error("eviction without fault");
  // A start while idle is always taken, and the block is idle while the result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("still busy after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transaction not taken");

endmodule
